>>> design/tbd_pkg.sv
// Shared constants, codes and control structs for the timestamp button debouncer.
`default_nettype none

package tbd_pkg;

    localparam int NUM_BUTTONS = 3;
    localparam int BTN_IDX_W   = 2;
    localparam int TICK_W      = 32;
    localparam int DEB_W       = 16;
    localparam int OP_W        = 2;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 16;
    localparam int S_DATA_W    = 40;
    localparam int M_DATA_W    = 40;

    localparam logic [OP_W-1:0] OP_INIT = 2'd0;
    localparam logic [OP_W-1:0] OP_EDGE = 2'd1;
    localparam logic [OP_W-1:0] OP_POLL = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESSED  = 1'b1;

    localparam logic [DEB_W-1:0]       DEBOUNCE_RESET = 16'd50;
    localparam logic [NUM_BUTTONS-1:0] PRESSED_RESET  = 3'd6;

    // per-button command from the top level
    typedef struct packed {
        logic              fire;
        logic              do_init;
        logic              do_edge;
        logic              do_poll;
        logic              scan_live;
        logic              pin_level;
        logic              active_level;
        logic [TICK_W-1:0] now_tick;
        logic [DEB_W-1:0]  debounce_ticks;
    } btn_ctl_t;

    // per-button status back to the top level
    typedef struct packed {
        logic hit;
        logic cur;
        logic stable_next;
    } btn_stat_t;

endpackage

`default_nettype wire

>>> design/timestamp_button_debouncer_core.sv
// Top level of the timestamp button debouncer: stream ports, config, scan priority.
//
//  channel | dir | handshake           | payload
//  --------+-----+---------------------+----------------------------------------------
//  s_*     | in  | s_tvalid / s_tready | tuser: op; tdata: button_id, pins, now_tick
//  m_*     | out | m_tvalid / m_tready | tuser: event_valid; tdata: event fields, states
//  cfg_*   | in  | cfg_valid/cfg_ready | cfg_index 0 debounce delay, 1 pressed-level mask
//
// One transaction per cycle sustained while m_tready stays high. An accepted item sits in the input register,
// is processed through the per-button units and the priority pick, and its result
// lands in the output register.
// Stalls: the input register advances whenever the output register is empty or
// being taken; while a result waits, one more item can still be accepted into an
// empty input register, after which s_tready drops until m_tready returns.
// Reset clears all button state; the delay resets to 50, the pressed-level mask to 6.
// cfg_ready is always high.
`default_nettype none

module timestamp_button_debouncer_core (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // [1:0] button_id, [4:2] pin_levels, [36:5] now_tick, [39:37] zero
    input  wire logic [tbd_pkg::S_DATA_W-1:0]   s_tdata,
    // [1:0] op
    input  wire logic [tbd_pkg::OP_W-1:0]       s_tuser,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // [1:0] event_button, [2] event_pressed, [34:3] event_time,
    // [37:35] stable_states, [39:38] zero
    output logic [tbd_pkg::M_DATA_W-1:0]        m_tdata,
    // [0] event_valid
    output logic                                m_tuser,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [tbd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [tbd_pkg::CFG_DATA_W-1:0] cfg_data
);
    import tbd_pkg::*;

    // configuration
    logic [DEB_W-1:0]       debounce_reg;
    logic [NUM_BUTTONS-1:0] pressed_reg;

    // input register
    logic                   in_valid_reg;
    logic [OP_W-1:0]        in_op_reg;
    logic [BTN_IDX_W-1:0]   in_id_reg;
    logic [NUM_BUTTONS-1:0] in_pins_reg;
    logic [TICK_W-1:0]      in_now_reg;

    // output register
    logic                   out_valid_reg;
    logic                   out_event_reg;
    logic [BTN_IDX_W-1:0]   out_btn_reg;
    logic                   out_press_reg;
    logic [TICK_W-1:0]      out_time_reg;
    logic [NUM_BUTTONS-1:0] out_stable_reg;

    logic                   process;
    btn_ctl_t               ctl   [NUM_BUTTONS];
    btn_stat_t              stat  [NUM_BUTTONS];
    logic [NUM_BUTTONS-1:0] hit_vec;
    logic [NUM_BUTTONS-1:0] scan_live;
    logic [NUM_BUTTONS-1:0] first_hit;
    logic [NUM_BUTTONS-1:0] stable_next;
    logic                   ev_valid;
    logic [BTN_IDX_W-1:0]   ev_btn;
    logic                   ev_press;

    assign process   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || process;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg <= DEBOUNCE_RESET;
            pressed_reg  <= PRESSED_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_DEBOUNCE: debounce_reg <= cfg_data[DEB_W-1:0];
                CFG_PRESSED:  pressed_reg  <= cfg_data[NUM_BUTTONS-1:0];
                default:      ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_op_reg   <= s_tuser;
            in_id_reg   <= s_tdata[BTN_IDX_W-1:0];
            in_pins_reg <= s_tdata[BTN_IDX_W +: NUM_BUTTONS];
            in_now_reg  <= s_tdata[BTN_IDX_W+NUM_BUTTONS +: TICK_W];
        end
    end

    // per-button commands; an edge for an id past the last button matches nothing
    always_comb
    begin
        for (int b = 0; b < NUM_BUTTONS; b++)
        begin
            ctl[b].fire           = process;
            ctl[b].do_init        = (in_op_reg == OP_INIT);
            ctl[b].do_edge        = (in_op_reg == OP_EDGE)
                                    && (in_id_reg == BTN_IDX_W'(b));
            ctl[b].do_poll        = (in_op_reg == OP_POLL);
            ctl[b].scan_live      = scan_live[b];
            ctl[b].pin_level      = in_pins_reg[b];
            ctl[b].active_level   = pressed_reg[b];
            ctl[b].now_tick       = in_now_reg;
            ctl[b].debounce_ticks = debounce_reg;
        end
    end

    for (genvar g = 0; g < NUM_BUTTONS; g++)
    begin : g_btn
        tbd_btn_unit u_btn (
            .clk   (clk),
            .rst_n (rst_n),
            .ctl   (ctl[g]),
            .stat  (stat[g])
        );
        assign hit_vec[g]     = stat[g].hit;
        assign stable_next[g] = stat[g].stable_next;
    end

    // poll stops at the first changed button; later buttons stay untouched
    always_comb
    begin
        scan_live[0] = 1'b1;
        for (int b = 1; b < NUM_BUTTONS; b++)
        begin
            scan_live[b] = scan_live[b-1] && !hit_vec[b-1];
        end
    end

    assign first_hit = hit_vec & scan_live;
    assign ev_valid  = (in_op_reg == OP_POLL) && (|first_hit);

    always_comb
    begin
        ev_btn   = '0;
        ev_press = 1'b0;
        for (int b = 0; b < NUM_BUTTONS; b++)
        begin
            if (first_hit[b])
            begin
                ev_btn   = BTN_IDX_W'(b);
                ev_press = stat[b].cur;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (process)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // fields other than the states read zero when no event
    always_ff @(posedge clk)
    begin
        if (process)
        begin
            out_event_reg  <= ev_valid;
            out_btn_reg    <= ev_valid ? ev_btn : '0;
            out_press_reg  <= ev_valid && ev_press;
            out_time_reg   <= ev_valid ? in_now_reg : '0;
            out_stable_reg <= stable_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_event_reg;
    assign m_tdata  = {{(M_DATA_W-BTN_IDX_W-1-TICK_W-NUM_BUTTONS){1'b0}},
                       out_stable_reg, out_time_reg, out_press_reg, out_btn_reg};

    // at most one button reports per poll
    a_one_event: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(first_hit))
        else $error("more than one button picked in one poll");

    // an event leaves the reported button in the reported state
    a_event_state: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_event_reg) |-> (out_stable_reg[out_btn_reg] == out_press_reg))
        else $error("event disagrees with stable states");

    // only a poll can produce an event
    a_event_poll: assert property (@(posedge clk) disable iff (!rst_n)
        (process && (in_op_reg != OP_POLL)) |=> !out_event_reg)
        else $error("event from a non-poll operation");

    // an empty output register never blocks input
    a_no_block: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> s_tready)
        else $error("input stalled with empty output register");

endmodule

`default_nettype wire

>>> design/tbd_btn_unit.sv
// One button: pending flag, debounced state, edge timestamp and the age check.
`default_nettype none

module tbd_btn_unit (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire tbd_pkg::btn_ctl_t ctl,
    output tbd_pkg::btn_stat_t     stat
);
    import tbd_pkg::*;

    logic              pending_reg;
    logic              pending_next;
    logic              stable_reg;
    logic              stable_next;
    logic [TICK_W-1:0] edge_time_reg;
    logic [TICK_W-1:0] edge_time_next;
    logic [TICK_W-1:0] age;
    logic              cur;
    logic              due;
    logic              hit;

    assign cur = (ctl.pin_level == ctl.active_level);
    assign age = ctl.now_tick - edge_time_reg;   // wraps mod 2^32
    assign due = pending_reg && (age >= {{(TICK_W-DEB_W){1'b0}}, ctl.debounce_ticks});
    assign hit = due && (cur != stable_reg);

    always_comb
    begin
        pending_next   = pending_reg;
        stable_next    = stable_reg;
        edge_time_next = edge_time_reg;
        if (ctl.fire)
        begin
            if (ctl.do_init)
            begin
                stable_next    = cur;
                pending_next   = 1'b0;
                edge_time_next = ctl.now_tick;
            end
            else if (ctl.do_edge)
            begin
                pending_next   = 1'b1;
                edge_time_next = ctl.now_tick;
            end
            else if (ctl.do_poll && ctl.scan_live && due)
            begin
                pending_next = 1'b0;
                if (hit)
                begin
                    stable_next = cur;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg   <= 1'b0;
            stable_reg    <= 1'b0;
            edge_time_reg <= '0;
        end
        else
        begin
            pending_reg   <= pending_next;
            stable_reg    <= stable_next;
            edge_time_reg <= edge_time_next;
        end
    end

    assign stat.hit         = hit;
    assign stat.cur         = cur;
    assign stat.stable_next = stable_next;

endmodule

`default_nettype wire

>>> tb/timestamp_button_debouncer_core_tb.sv
// Self-checking testbench for timestamp_button_debouncer_core: directed and random streams.
`default_nettype none

module timestamp_button_debouncer_core_tb;

    import tbd_pkg::*;

    // op value with no operation behind it, and a button id past the last button
    localparam logic [OP_W-1:0]      OP_UNUSED   = 2'd3;
    localparam logic [BTN_IDX_W-1:0] BTN_NONE    = 2'd3;
    // worst case per item is the longest random idle gap on each side plus the pipeline;
    // roughly 500 transactions plus drains fit far below this
    localparam int                   CYCLE_LIMIT = 400000;
    localparam int                   MAX_REPORTS = 10;

    // one predicted or observed result transaction
    typedef struct packed {
        logic                   has_event;
        logic [BTN_IDX_W-1:0]   button;
        logic                   pressed;
        logic [TICK_W-1:0]      stamp;
        logic [NUM_BUTTONS-1:0] states;
    } debounce_result_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata;
    logic [OP_W-1:0]       s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  m_tuser;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // predictor copy of the block state and registers
    logic [NUM_BUTTONS-1:0] pend_q       = '0;
    logic [NUM_BUTTONS-1:0] stable_q     = '0;
    logic [TICK_W-1:0]      stamp_q [NUM_BUTTONS] = '{default: '0};
    logic [DEB_W-1:0]       deb_ticks    = DEBOUNCE_RESET;
    logic [NUM_BUTTONS-1:0] press_levels = PRESSED_RESET;

    debounce_result_t expected_reports[$];
    int               mismatch_count = 0;
    int               cycle_count    = 0;
    // when set, that side never idles
    logic             in_idle_off    = 1'b0;
    logic             out_idle_off   = 1'b0;

    timestamp_button_debouncer_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run-away guard
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Applies one operation to the predictor state and returns the result it
    // should produce. Poll scans upward and stops at the first confirmed change;
    // aged buttons without a change just drop their pending flag.
    function automatic debounce_result_t debounce_predict(input logic [OP_W-1:0] op,
                                                          input logic [BTN_IDX_W-1:0] id,
                                                          input logic [NUM_BUTTONS-1:0] pins,
                                                          input logic [TICK_W-1:0] now);
        debounce_result_t res;
        logic             hit;
        logic             cur;
        res = '0;
        hit = 1'b0;
        case (op)
            OP_INIT:
            begin
                for (int b = 0; b < NUM_BUTTONS; b++)
                begin
                    stable_q[b] = (pins[b] == press_levels[b]);
                    pend_q[b]   = 1'b0;
                    stamp_q[b]  = now;
                end
            end
            OP_EDGE:
            begin
                if (id < NUM_BUTTONS)
                begin
                    pend_q[id]  = 1'b1;
                    stamp_q[id] = now;
                end
            end
            OP_POLL:
            begin
                for (int b = 0; b < NUM_BUTTONS && !hit; b++)
                begin
                    // wrapping age against the zero-extended delay
                    if (pend_q[b] && (now - stamp_q[b]) >= {16'd0, deb_ticks})
                    begin
                        pend_q[b] = 1'b0;
                        cur = (pins[b] == press_levels[b]);
                        if (cur != stable_q[b])
                        begin
                            stable_q[b]   = cur;
                            hit           = 1'b1;
                            res.has_event = 1'b1;
                            res.button    = b[BTN_IDX_W-1:0];
                            res.pressed   = cur;
                            res.stamp     = now;
                        end
                    end
                end
            end
            default: ;
        endcase
        res.states = stable_q;
        return res;
    endfunction

    // One input transaction: random idle gap, then hold valid until taken.
    // Valid stays high across back-to-back items, so it is never dropped and
    // raised in the same step.
    task automatic send_item(input logic [OP_W-1:0] op, input logic [BTN_IDX_W-1:0] id,
                             input logic [NUM_BUTTONS-1:0] pins, input logic [TICK_W-1:0] now);
        int gap;
        gap = in_idle_off ? 0 : $urandom_range(0, 8);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {3'd0, now, pins, id};
        do
            @(posedge clk);
        while (!s_tready);
        expected_reports.push_back(debounce_predict(op, id, pins, now));
    endtask

    // Stop the input side and let every outstanding result come back,
    // then wait out the two-stage pipeline.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_reports.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Register write, only from idle; the predictor takes the same value.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_DEBOUNCE: deb_ticks    = value;
            CFG_PRESSED:  press_levels = value[NUM_BUTTONS-1:0];
            default: ;
        endcase
    endtask

    // Output side: random stall before each transaction, some stretches none.
    initial
    begin
        int stall;
        m_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = out_idle_off ? 0 : $urandom_range(0, 8);
            if (stall != 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!(m_tvalid && m_tready));
        end
    end

    // Result checker: every transaction against the oldest prediction.
    always @(posedge clk)
    begin
        debounce_result_t got;
        debounce_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.has_event = m_tuser;
            got.button    = m_tdata[1:0];
            got.pressed   = m_tdata[2];
            got.stamp     = m_tdata[34:3];
            got.states    = m_tdata[37:35];
            if (expected_reports.size() == 0)
            begin
                if (mismatch_count < MAX_REPORTS)
                    $display("unexpected result: ev=%0b btn=%0d prs=%0b t=%h st=%b",
                             got.has_event, got.button, got.pressed, got.stamp, got.states);
                mismatch_count++;
            end
            else
            begin
                want = expected_reports.pop_front();
                if (got.has_event !== want.has_event || got.button !== want.button ||
                    got.pressed !== want.pressed || got.stamp !== want.stamp ||
                    got.states !== want.states)
                begin
                    if (mismatch_count < MAX_REPORTS)
                        $display("mismatch: ev %0b/%0b btn %0d/%0d prs %0b/%0b t %h/%h st %b/%b",
                                 want.has_event, got.has_event, want.button, got.button,
                                 want.pressed, got.pressed, want.stamp, got.stamp,
                                 want.states, got.states);
                    mismatch_count++;
                end
            end
        end
    end

    // Nothing pending at reset, unused op, button id out of range.
    task automatic test_idle_ops();
        send_item(OP_POLL, 2'd0, 3'b000, 32'd0);
        send_item(OP_UNUSED, BTN_NONE, 3'b111, 32'hFFFF_FFFF);
        send_item(OP_EDGE, BTN_NONE, 3'b111, 32'hFFFF_FFFF);
        // stamp still zero and nothing pending: huge age, still no event
        send_item(OP_POLL, 2'd1, 3'b111, 32'hFFFF_FFFF);
    endtask

    // Aging threshold, scan priority, unchanged-but-aged, tick wraparound.
    task automatic test_scan_order();
        send_item(OP_INIT, 2'd0, 3'b000, 32'd0);
        send_item(OP_EDGE, 2'd0, 3'b000, 32'd100);
        send_item(OP_POLL, 2'd0, 3'b111, 32'd149);      // one tick too young
        send_item(OP_POLL, 2'd0, 3'b111, 32'd150);      // exactly aged: release
        send_item(OP_EDGE, 2'd1, 3'b000, 32'd200);
        send_item(OP_EDGE, 2'd2, 3'b000, 32'd200);
        send_item(OP_POLL, 2'd0, 3'b110, 32'd250);      // button 1 wins, 2 waits
        send_item(OP_POLL, 2'd0, 3'b110, 32'd251);      // then button 2
        send_item(OP_EDGE, 2'd0, 3'b000, 32'd300);
        send_item(OP_EDGE, 2'd1, 3'b000, 32'd300);
        send_item(OP_POLL, 2'd0, 3'b001, 32'd400);      // 0 unchanged, scan goes on to 1
        send_item(OP_INIT, 2'd0, 3'b101, 32'hFFFF_FFF0);
        send_item(OP_EDGE, 2'd2, 3'b000, 32'hFFFF_FFF0);
        send_item(OP_POLL, 2'd0, 3'b001, 32'h0000_0021); // wrapped age 49
        send_item(OP_POLL, 2'd0, 3'b001, 32'h0000_0022); // wrapped age 50
    endtask

    // Delay and pressed-level registers at their extremes; upper data bits
    // of the pressed-level write must be dropped.
    task automatic test_register_extremes();
        write_register(CFG_DEBOUNCE, 16'd0);
        write_register(CFG_PRESSED, 16'hFFFF);
        send_item(OP_EDGE, 2'd0, 3'b000, 32'd5);
        send_item(OP_POLL, 2'd0, 3'b001, 32'd5);        // zero delay confirms at once
        write_register(CFG_DEBOUNCE, 16'hFFFF);
        send_item(OP_EDGE, 2'd1, 3'b000, 32'd1000);
        send_item(OP_POLL, 2'd0, 3'b010, 32'd1000 + 32'd65534);
        send_item(OP_POLL, 2'd0, 3'b010, 32'd1000 + 32'd65535);
        write_register(CFG_PRESSED, 16'hFFF8);
        send_item(OP_INIT, 2'd0, 3'b010, 32'd70000);
    endtask

    // Phases of edge/poll traffic with a moving tick; each phase reprograms
    // both registers. Ticks advance mostly in steps scaled to the delay so
    // edges age across the threshold, with occasional jumps anywhere.
    task automatic test_random_traffic();
        logic [TICK_W-1:0]      now;
        logic [OP_W-1:0]        op;
        logic [BTN_IDX_W-1:0]   id;
        logic [NUM_BUTTONS-1:0] pins;
        logic [NUM_BUTTONS-1:0] lv;
        int                     deb;
        int                     r;
        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0:       deb = 0;
                1:       deb = 65535;
                2:       deb = 1;
                5:       deb = $urandom_range(0, 65535);
                default: deb = $urandom_range(2, 400);
            endcase
            case (phase)
                0:       lv = 3'b000;
                1:       lv = 3'b111;
                default: lv = 3'($urandom_range(0, 7));
            endcase
            write_register(CFG_DEBOUNCE, deb[15:0]);
            write_register(CFG_PRESSED, {13'($urandom_range(0, 8191)), lv});
            now = $urandom;
            for (int i = 0; i < 75; i++)
            begin
                if (i % 25 == 0)
                begin
                    in_idle_off  = (phase == 0) || ($urandom_range(0, 3) == 0);
                    out_idle_off = (phase == 0) || ($urandom_range(0, 3) == 0);
                end
                r = $urandom_range(0, 99);
                if (r < 4)
                    op = OP_INIT;
                else if (r < 8)
                    op = OP_UNUSED;
                else if (r < 45)
                    op = OP_EDGE;
                else
                    op = OP_POLL;
                if (op == OP_EDGE && $urandom_range(0, 9) != 0)
                    id = 2'($urandom_range(0, 2));
                else
                    id = 2'($urandom_range(0, 3));
                pins = 3'($urandom_range(0, 7));
                r = $urandom_range(0, 9);
                if (r < 7)
                    now = now + $urandom_range(0, deb / 4 + 3);
                else if (r < 9)
                    now = now + $urandom_range(deb / 2, deb + deb / 2 + 2);
                else
                    now = $urandom;
                send_item(op, id, pins, now);
            end
        end
        in_idle_off  = 1'b0;
        out_idle_off = 1'b0;
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_idle_ops();
        test_scan_order();
        test_register_extremes();
        test_random_traffic();

        drain();
        repeat (6) @(posedge clk);
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

`default_nettype wire
